// ===== rtl/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants for the windowed tachometer speed estimator.
// ----------------------------------------------------------------------------
package wts_pkg;

    // Word kinds on the input channel
    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_CALC = 1'b1
    } action_t;

    localparam int unsigned SPEED_WIDTH   = 21;
    localparam int unsigned MAG_WIDTH     = SPEED_WIDTH - 1;
    localparam int unsigned TICK_MS_WIDTH = 4;

    // Milliseconds-to-seconds scale applied to a window difference
    localparam longint unsigned SCALE = 1000;

    localparam logic [TICK_MS_WIDTH-1:0] TICK_MS_RESET = 4'd1;
    localparam logic [MAG_WIDTH-1:0]     SPEED_MAG_MAX = {MAG_WIDTH{1'b1}};

    typedef logic signed [SPEED_WIDTH-1:0] speed_t;
    typedef logic [TICK_MS_WIDTH-1:0]      tick_ms_t;

endpackage

// ===== rtl/wts_in_if.sv =====
// ----------------------------------------------------------------------------
// wts_in_if
// Input channel: tick or calc words with both quadrature positions.
// ----------------------------------------------------------------------------
interface wts_in_if #(
    parameter int POS_WIDTH = 16
);
    logic                 valid;
    logic                 ready;
    wts_pkg::action_t     action;
    logic [POS_WIDTH-1:0] left_pos;
    logic [POS_WIDTH-1:0] right_pos;

    modport source (output valid, output action, output left_pos, output right_pos,
                    input ready);
    modport sink   (input valid, input action, input left_pos, input right_pos,
                    output ready);
endinterface

// ===== rtl/wts_out_if.sv =====
// ----------------------------------------------------------------------------
// wts_out_if
// Output channel: held speeds of both wheels and the sample flag.
// ----------------------------------------------------------------------------
interface wts_out_if;
    logic                valid;
    logic                ready;
    wts_pkg::speed_t     left_speed;
    wts_pkg::speed_t     right_speed;
    logic                sample_taken;

    modport source (output valid, output left_speed, output right_speed,
                    output sample_taken, input ready);
    modport sink   (input valid, input left_speed, input right_speed,
                    input sample_taken, output ready);
endinterface

// ===== rtl/wts_cell.sv =====
// ----------------------------------------------------------------------------
// wts_cell
// One history cell: holds a left/right position pair, loads from its neighbour.
// ----------------------------------------------------------------------------
module wts_cell #(
    parameter int POS_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  logic [POS_WIDTH-1:0] left_in,
    input  logic [POS_WIDTH-1:0] right_in,
    output logic [POS_WIDTH-1:0] left_q,
    output logic [POS_WIDTH-1:0] right_q
);

    logic [POS_WIDTH-1:0] left_reg;
    logic [POS_WIDTH-1:0] right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
        end
        else if (shift_en)
        begin
            left_reg  <= left_in;
            right_reg <= right_in;
        end
    end

    assign left_q  = left_reg;
    assign right_q = right_reg;

endmodule

// ===== rtl/wts_speed_lane.sv =====
// ----------------------------------------------------------------------------
// wts_speed_lane
// Two-stage speed datapath for one wheel: window difference, then scaling by
// SCALE / DIVISOR through a split reciprocal multiply, truncated and saturated.
// ----------------------------------------------------------------------------
module wts_speed_lane #(
    parameter int POS_WIDTH = 16,
    parameter int DIVISOR   = 80
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [POS_WIDTH-1:0] newest,
    input  logic [POS_WIDTH-1:0] oldest,
    output wts_pkg::speed_t      speed
);

    localparam longint unsigned DIV = longint'(DIVISOR);
    // Smallest magnitude whose scaled value no longer fits the field
    localparam longint unsigned SAT_MAG =
        ((longint'(1) << wts_pkg::MAG_WIDTH) * DIV + wts_pkg::SCALE - 1) / wts_pkg::SCALE;
    localparam int NW    = $clog2(SAT_MAG);
    localparam int DW    = $clog2(DIV + 1);
    localparam int SHIFT = NW + DW;
    localparam longint unsigned MULT = ((wts_pkg::SCALE << SHIFT) + DIV - 1) / DIV;
    localparam int MW  = $clog2(MULT + 1);
    localparam int MLO = MW / 2;
    localparam int MHI = MW - MLO;
    localparam int PW  = NW + MW;
    localparam logic [MLO-1:0] M_LO = MLO'(MULT);
    localparam logic [MHI-1:0] M_HI = MHI'(MULT >> MLO);

    logic                 neg_next;
    logic [POS_WIDTH-1:0] diff;
    logic                 sat_next;
    logic [NW-1:0]        mag_next;
    logic                 neg_reg;
    logic                 sat_reg;
    logic [NW-1:0]        mag_reg;

    logic [NW+MLO-1:0]    pp_lo_next;
    logic [NW+MHI-1:0]    pp_hi_next;
    logic [NW+MLO-1:0]    pp_lo_reg;
    logic [NW+MHI-1:0]    pp_hi_reg;
    logic                 neg2_reg;
    logic                 sat2_reg;

    logic [PW-1:0]                  prod;
    logic [wts_pkg::MAG_WIDTH-1:0]  quot;
    logic [wts_pkg::MAG_WIDTH-1:0]  mag_out;

    always_comb
    begin
        neg_next = newest < oldest;
        diff     = neg_next ? (oldest - newest) : (newest - oldest);
        sat_next = 64'(diff) >= SAT_MAG;
        mag_next = NW'(diff);
    end

    assign pp_lo_next = (NW+MLO)'(mag_reg) * (NW+MLO)'(M_LO);
    assign pp_hi_next = (NW+MHI)'(mag_reg) * (NW+MHI)'(M_HI);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg   <= neg_next;
            sat_reg   <= sat_next;
            mag_reg   <= mag_next;
            neg2_reg  <= neg_reg;
            sat2_reg  <= sat_reg;
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
        end
    end

    always_comb
    begin
        prod    = (PW'(pp_hi_reg) << MLO) + PW'(pp_lo_reg);
        quot    = wts_pkg::MAG_WIDTH'(prod >> SHIFT);
        mag_out = sat2_reg ? wts_pkg::SPEED_MAG_MAX : quot;
        speed   = neg2_reg ? -wts_pkg::speed_t'({1'b0, mag_out})
                           :  wts_pkg::speed_t'({1'b0, mag_out});
    end

endmodule

// ===== rtl/windowed_tacho_speed.sv =====
// ----------------------------------------------------------------------------
// windowed_tacho_speed
// Two-wheel tachometer: sampled position history and windowed speed estimate.
// ----------------------------------------------------------------------------
// Input words (in_ch) are either ticks or calc requests. A tick adds tick_ms
// to the period accumulator; when it reaches SAMPLE_PERIOD_MS both positions
// are pushed into a chain of HISTORY_DEPTH cells (newest at the head, oldest
// at the tail). A calc word turns head minus tail into steps per second and
// latches it as the held speed. Every input word yields one output word
// (out_ch) carrying the held speeds and the sample flag.
// tick_ms is written via cfg_we/cfg_wdata; the user must do so only while the
// block is idle, which the block itself leaves unchecked. in_ch.valid passes
// v1_reg and v2_reg to out_valid_reg. The history chain updates at acceptance
// and the two-stage scaling pipe per wheel lets a word enter every cycle
// unless stalled. Reset clears the history, the accumulator and the held
// speeds and sets tick_ms to 1. When the receiver stalls the whole pipe holds
// and in_ch.ready drops; an empty output register keeps in_ch.ready high.
// ----------------------------------------------------------------------------
module windowed_tacho_speed #(
    parameter int HISTORY_DEPTH    = 17,
    parameter int SAMPLE_PERIOD_MS = 5,
    parameter int POS_WIDTH        = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  wts_pkg::tick_ms_t   cfg_wdata,
    wts_in_if.sink              in_ch,
    wts_out_if.source           out_ch
);

    localparam int DIVISOR = SAMPLE_PERIOD_MS * (HISTORY_DEPTH - 1);
    localparam int AW      = $clog2(SAMPLE_PERIOD_MS + 16);

    wts_pkg::tick_ms_t tick_ms_reg;
    logic [AW-1:0]     accum_reg;
    logic [AW-1:0]     accum_next;
    logic [AW-1:0]     accum_sum;

    logic en;
    logic accept;
    logic is_tick;
    logic sample_hit;

    logic             v1_reg;
    logic             v2_reg;
    logic             out_valid_reg;
    wts_pkg::action_t act1_reg;
    wts_pkg::action_t act2_reg;
    logic             samp1_reg;
    logic             samp2_reg;
    logic             samp_out_reg;

    wts_pkg::speed_t left_held_reg;
    wts_pkg::speed_t right_held_reg;
    wts_pkg::speed_t left_lane_speed;
    wts_pkg::speed_t right_lane_speed;

    logic [POS_WIDTH-1:0] left_chain  [HISTORY_DEPTH];
    logic [POS_WIDTH-1:0] right_chain [HISTORY_DEPTH];

    // Whole pipe advances when the output register is free or being taken
    assign en           = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = en;
    assign accept       = in_ch.valid && en;
    assign is_tick      = in_ch.action == wts_pkg::ACT_TICK;

    always_comb
    begin
        accum_sum  = accum_reg + AW'(tick_ms_reg);
        sample_hit = accept && is_tick && (accum_sum >= AW'(SAMPLE_PERIOD_MS));
        accum_next = accum_reg;
        if (accept && is_tick)
        begin
            accum_next = sample_hit ? '0 : accum_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms_reg <= wts_pkg::TICK_MS_RESET;
            accum_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tick_ms_reg <= cfg_wdata;
            end
            accum_reg <= accum_next;
        end
    end

    // History chain: on a sample the head loads the input positions and each other cell loads from its neighbour
    for (genvar k = 0; k < HISTORY_DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            wts_cell #(.POS_WIDTH(POS_WIDTH)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (sample_hit),
                .left_in  (in_ch.left_pos),
                .right_in (in_ch.right_pos),
                .left_q   (left_chain[k]),
                .right_q  (right_chain[k])
            );
        end
        else
        begin : g_body
            wts_cell #(.POS_WIDTH(POS_WIDTH)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (sample_hit),
                .left_in  (left_chain[k-1]),
                .right_in (right_chain[k-1]),
                .left_q   (left_chain[k]),
                .right_q  (right_chain[k])
            );
        end
    end

    wts_speed_lane #(.POS_WIDTH(POS_WIDTH), .DIVISOR(DIVISOR)) u_left_lane (
        .clk    (clk),
        .en     (en),
        .newest (left_chain[0]),
        .oldest (left_chain[HISTORY_DEPTH-1]),
        .speed  (left_lane_speed)
    );

    wts_speed_lane #(.POS_WIDTH(POS_WIDTH), .DIVISOR(DIVISOR)) u_right_lane (
        .clk    (clk),
        .en     (en),
        .newest (right_chain[0]),
        .oldest (right_chain[HISTORY_DEPTH-1]),
        .speed  (right_lane_speed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_held_reg  <= '0;
            right_held_reg <= '0;
        end
        else if (en)
        begin
            v1_reg        <= in_ch.valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
            // Latch new speeds as a calc word reaches the output register
            if (v2_reg && act2_reg == wts_pkg::ACT_CALC)
            begin
                left_held_reg  <= left_lane_speed;
                right_held_reg <= right_lane_speed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act1_reg     <= in_ch.action;
            samp1_reg    <= sample_hit;
            act2_reg     <= act1_reg;
            samp2_reg    <= samp1_reg;
            samp_out_reg <= samp2_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.left_speed   = left_held_reg;
    assign out_ch.right_speed  = right_held_reg;
    assign out_ch.sample_taken = samp_out_reg;

endmodule

// ===== dv/tb_windowed_tacho_speed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_tacho_speed
// Self-checking bench for the windowed tachometer. A short table of tick and
// calc words runs first, then phases of random words at several tick_ms
// settings. A local model of the sample histories and held speeds predicts
// every output word but those of typed table rows; both channels idle at
// random, and one phase stalls the receiver long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_windowed_tacho_speed;

    localparam int HISTORY_DEPTH    = 17;
    localparam int SAMPLE_PERIOD_MS = 5;
    localparam int POS_WIDTH        = 16;
    localparam int WINDOW_MS        = SAMPLE_PERIOD_MS * (HISTORY_DEPTH - 1);
    localparam int PIPE_LATENCY     = 3;
    localparam int SETTLE_CYCLES    = 4 * PIPE_LATENCY;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PHASES    = 10;
    localparam int WORDS_PER_PHASE  = 100;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int REPORT_LIMIT     = 10;
    localparam int MAX_GAP          = 14;

    typedef logic [POS_WIDTH-1:0] pos_t;

    typedef struct {
        wts_pkg::speed_t left;
        wts_pkg::speed_t right;
        logic            sampled;
    } speed_word_t;

    typedef struct {
        wts_pkg::action_t act;
        pos_t             left;
        pos_t             right;
        bit               typed;
        speed_word_t      want;
    } plan_row_t;

    localparam wts_pkg::tick_ms_t PHASE_TICK_MS [8] =
        '{4'd15, 4'd0, 4'd5, 4'd1, 4'd4, 4'd2, 4'd3, 4'd15};

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    wts_pkg::tick_ms_t cfg_wdata;

    wts_in_if #(.POS_WIDTH(POS_WIDTH)) in_ch ();
    wts_out_if                         out_ch ();

    windowed_tacho_speed #(
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS),
        .POS_WIDTH        (POS_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Local copy of the tachometer state
    pos_t              left_hist [HISTORY_DEPTH];
    pos_t              right_hist [HISTORY_DEPTH];
    int unsigned       write_slot;
    int unsigned       period_accum;
    wts_pkg::tick_ms_t model_tick_ms;
    wts_pkg::speed_t   held_left;
    wts_pkg::speed_t   held_right;

    speed_word_t expected_words [$];
    speed_word_t head_word;
    int          mismatches;
    int          cycles;
    bit          in_burst;
    bit          out_burst;
    bit          hold_request;

    // Reset state first, then extremes; typed rows can be read off at a glance
    plan_row_t directed_plan [16] = '{
        '{wts_pkg::ACT_CALC, 16'h1234, 16'h4321, 1'b1, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'hFFFF, 16'h0000, 1'b1, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'h0000, 16'hFFFF, 1'b1, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'hAAAA, 16'h5555, 1'b1, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'h5555, 16'hAAAA, 1'b1, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'hFFFF, 16'h0000, 1'b1, '{21'sd0, 21'sd0, 1'b1}},
        '{wts_pkg::ACT_CALC, 16'h0000, 16'h0000, 1'b1, '{21'sd819187, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'h0000, 16'hFFFF, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'h8000, 16'h7FFF, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'h7FFF, 16'h8000, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'h0001, 16'hFFFE, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'h0000, 16'hFFFF, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_CALC, 16'hFFFF, 16'hFFFF, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_TICK, 16'h0050, 16'h0000, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_CALC, 16'h0000, 16'h0000, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
        '{wts_pkg::ACT_CALC, 16'hFFFF, 16'h0000, 1'b0, '{21'sd0, 21'sd0, 1'b0}}
    };

    // (newest - oldest) in steps per second, truncated toward zero
    function automatic wts_pkg::speed_t window_rate(pos_t newest, pos_t oldest);
        longint diff;
        longint mag;
        diff = newest;
        diff = diff - oldest;
        mag  = (diff < 0) ? -diff : diff;
        mag  = mag * longint'(wts_pkg::SCALE) / WINDOW_MS;
        if (mag > longint'(wts_pkg::SPEED_MAG_MAX))
            mag = longint'(wts_pkg::SPEED_MAG_MAX);
        return (diff < 0) ? wts_pkg::speed_t'(-mag) : wts_pkg::speed_t'(mag);
    endfunction

    function automatic speed_word_t predict_speed_word(wts_pkg::action_t act,
                                                       pos_t l, pos_t r);
        speed_word_t w;
        int unsigned newest;
        w.sampled = 1'b0;
        if (act == wts_pkg::ACT_TICK)
        begin
            period_accum += model_tick_ms;
            if (period_accum >= SAMPLE_PERIOD_MS)
            begin
                period_accum           = 0;
                left_hist[write_slot]  = l;
                right_hist[write_slot] = r;
                write_slot = (write_slot == HISTORY_DEPTH - 1) ? 0 : write_slot + 1;
                w.sampled  = 1'b1;
            end
        end
        else
        begin
            // oldest entry sits at the slot to be overwritten next
            newest     = (write_slot == 0) ? HISTORY_DEPTH - 1 : write_slot - 1;
            held_left  = window_rate(left_hist[newest], left_hist[write_slot]);
            held_right = window_rate(right_hist[newest], right_hist[write_slot]);
        end
        w.left  = held_left;
        w.right = held_right;
        return w;
    endfunction

    task automatic send_word(wts_pkg::action_t act, pos_t l, pos_t r, bit typed,
                             speed_word_t want);
        int          gap;
        speed_word_t w;
        gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.left_pos  <= l;
        in_ch.right_pos <= r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        w = predict_speed_word(act, l, r);
        expected_words.push_back(typed ? want : w);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tick_ms(wts_pkg::tick_ms_t value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        model_tick_ms  = value;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_windowed_tacho_speed NOT OK");
        $finish;
    end

    initial
    begin : receiver
        int gap;
        out_ch.ready <= 1'b0;
        forever
        begin
            if (hold_request)
            begin
                // hold off long enough for the pipe to fill and stall the input
                hold_request  = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            gap = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: left %0d right %0d sample %0b",
                             out_ch.left_speed, out_ch.right_speed, out_ch.sample_taken);
            end
            else
            begin
                head_word = expected_words.pop_front();
                if (out_ch.left_speed !== head_word.left ||
                    out_ch.right_speed !== head_word.right ||
                    out_ch.sample_taken !== head_word.sampled)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                 head_word.left, head_word.right, head_word.sampled,
                                 out_ch.left_speed, out_ch.right_speed,
                                 out_ch.sample_taken);
                end
            end
        end
    end

    initial
    begin : stimulus
        speed_word_t       no_want;
        wts_pkg::tick_ms_t phase_ms;
        pos_t              lp;
        pos_t              rp;
        int                lv;
        int                rv;
        int                kind;
        wts_pkg::action_t  act;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= wts_pkg::TICK_MS_RESET;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= wts_pkg::ACT_TICK;
        in_ch.left_pos  <= '0;
        in_ch.right_pos <= '0;
        in_burst     = 1'b0;
        out_burst    = 1'b0;
        hold_request = 1'b0;
        mismatches   = 0;
        no_want      = '{21'sd0, 21'sd0, 1'b0};

        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            left_hist[i]  = '0;
            right_hist[i] = '0;
        end
        write_slot    = 0;
        period_accum  = 0;
        model_tick_ms = wts_pkg::TICK_MS_RESET;
        held_left     = '0;
        held_right    = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            send_word(directed_plan[i].act, directed_plan[i].left, directed_plan[i].right,
                      directed_plan[i].typed, directed_plan[i].want);

        lp = '0;
        rp = '0;
        lv = 100;
        rv = -100;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            phase_ms = (phase < 8) ? PHASE_TICK_MS[phase]
                                   : wts_pkg::tick_ms_t'($urandom_range(0, 15));
            write_tick_ms(phase_ms);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n % 25 == 0)
                begin
                    in_burst  = ($urandom_range(0, 3) == 0);
                    out_burst = ($urandom_range(0, 3) == 0);
                end
                if (phase == 2 && n == 0)
                begin
                    in_burst     = 1'b1;
                    hold_request = 1'b1;
                end
                // let every word out before carrying on
                if (phase == 4 && n == 50)
                    wait_drained();

                kind = $urandom_range(0, 19);
                if (kind == 0)
                begin
                    // full sweep from one end of the range
                    lp = {POS_WIDTH{$urandom_range(0, 1) == 1}};
                    rp = {POS_WIDTH{$urandom_range(0, 1) == 1}};
                    lv = (lp == '0) ? 4095 : -4095;
                    rv = (rp == '0) ? 4095 : -4095;
                end
                else if (kind == 1)
                begin
                    lv = int'($urandom_range(0, 8000)) - 4000;
                    rv = int'($urandom_range(0, 8000)) - 4000;
                end

                act = ($urandom_range(0, 3) == 0) ? wts_pkg::ACT_CALC : wts_pkg::ACT_TICK;
                if (kind < 15)
                begin
                    lp = lp + pos_t'(lv);
                    rp = rp + pos_t'(rv);
                end
                else if (kind < 17)
                begin
                    lp = {POS_WIDTH{$urandom_range(0, 1) == 1}};
                    rp = {POS_WIDTH{$urandom_range(0, 1) == 1}};
                end
                else
                begin
                    lp = pos_t'($urandom_range(0, 65535));
                    rp = pos_t'($urandom_range(0, 65535));
                end
                send_word(act, lp, rp, 1'b0, no_want);
            end
        end

        wait_drained();
        if (expected_words.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("tb_windowed_tacho_speed OK");
        else
            $display("tb_windowed_tacho_speed NOT OK");
        $finish;
    end

endmodule

// ===== windowed_tacho_speed.f =====
rtl/wts_pkg.sv
rtl/wts_in_if.sv
rtl/wts_out_if.sv
rtl/wts_cell.sv
rtl/wts_speed_lane.sv
rtl/windowed_tacho_speed.sv
dv/tb_windowed_tacho_speed.sv
